// File: design/ffha_pkg.sv
package ffha_pkg;

   localparam int ADDR_W = 12;
   localparam int SIZE_W = 13;
   localparam int HEAP_DEPTH = 1 << ADDR_W;

   localparam logic [SIZE_W-1:0] HEAP_BYTES   = 13'd4096;
   localparam logic [SIZE_W-1:0] HEADER_BYTES = 13'd17;
   localparam logic [SIZE_W-1:0] MIN_CAPACITY = 13'd24;
   localparam logic [SIZE_W-1:0] HEAP_MIN     = HEADER_BYTES + MIN_CAPACITY;

   localparam logic [1:0] CMD_ALLOC = 2'd0;
   localparam logic [1:0] CMD_FREE  = 2'd1;
   localparam logic [1:0] CMD_INIT  = 2'd2;

   localparam logic [1:0] STATUS_DONE = 2'd0;
   localparam logic [1:0] STATUS_OOM  = 2'd1;
   localparam logic [1:0] STATUS_NULL = 2'd2;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [SIZE_W-1:0] request_size;
      logic [ADDR_W-1:0] block_address;
   } ffha_req_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [ADDR_W-1:0] address;
   } ffha_rsp_type;

   typedef struct packed {
      logic              is_free;
      logic [SIZE_W-1:0] cap;
   } ffha_hdr_type;

endpackage

// File: design/ffha_engine.sv
module ffha_engine (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [12:0]               heap_bytes,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  ffha_pkg::ffha_req_type    cmd_data,
   output logic                      res_valid,
   input  logic                      res_ready,
   output ffha_pkg::ffha_rsp_type    res_data
);
   import ffha_pkg::*;

   typedef enum logic [9:0] {
      S_BOOT = 10'b0000000001,
      S_IDLE = 10'b0000000010,
      S_INIT = 10'b0000000100,
      S_RD   = 10'b0000001000,
      S_CHK  = 10'b0000010000,
      S_MRD  = 10'b0000100000,
      S_MCHK = 10'b0001000000,
      S_FIT  = 10'b0010000000,
      S_USE  = 10'b0100000000,
      S_DONE = 10'b1000000000
   } ffha_state_type;

   ffha_state_type state_ff, state_in;
   logic                free_op_ff, free_op_in;
   logic [SIZE_W-1:0]   q_ff, q_in;
   logic [ADDR_W-1:0]   h_ff, h_in;
   logic [ADDR_W-1:0]   o_ff, o_in;
   logic [ADDR_W-1:0]   n_ff, n_in;
   logic [SIZE_W-1:0]   cap_ff, cap_in;
   logic [SIZE_W-1:0]   heap_end_ff, heap_end_in;
   ffha_rsp_type        res_ff, res_in;

   ffha_hdr_type        hdr_mem_ff [HEAP_DEPTH];
   ffha_hdr_type        rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;
   logic                rd_en;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   ffha_hdr_type        wr_data;

   logic [SIZE_W-1:0]   heap_size;
   logic [SIZE_W:0]     next_rd;
   logic [SIZE_W:0]     next_cur;
   logic [SIZE_W:0]     merged;
   logic [SIZE_W:0]     split_need;
   logic [SIZE_W:0]     tail_off;
   logic [SIZE_W-1:0]   tail_cap;
   logic [SIZE_W-1:0]   req_q;

   // init clamps the configured size into the legal range
   always_comb begin
      if (heap_bytes > HEAP_BYTES) begin
         heap_size = HEAP_BYTES;
      end else if (heap_bytes < HEAP_MIN) begin
         heap_size = HEAP_MIN;
      end else begin
         heap_size = heap_bytes;
      end
   end

   assign req_q      = (cmd_data.request_size < MIN_CAPACITY) ? MIN_CAPACITY
                                                              : cmd_data.request_size;
   assign next_rd    = {2'b0, o_ff} + {1'b0, HEADER_BYTES} + {1'b0, rd_data_ff.cap};
   assign next_cur   = {2'b0, o_ff} + {1'b0, HEADER_BYTES} + {1'b0, cap_ff};
   assign merged     = {1'b0, cap_ff} + {1'b0, HEADER_BYTES} + {1'b0, rd_data_ff.cap};
   assign split_need = {1'b0, q_ff} + {1'b0, HEAP_MIN};
   assign tail_off   = {2'b0, o_ff} + {1'b0, HEADER_BYTES} + {1'b0, q_ff};
   assign tail_cap   = cap_ff - q_ff - HEADER_BYTES;

   always_comb begin
      state_in    = state_ff;
      free_op_in  = free_op_ff;
      q_in        = q_ff;
      h_in        = h_ff;
      o_in        = o_ff;
      n_in        = n_ff;
      cap_in      = cap_ff;
      heap_end_in = heap_end_ff;
      res_in      = res_ff;
      rd_en       = 1'b0;
      rd_addr     = o_ff;
      wr_en       = 1'b0;
      wr_addr     = o_ff;
      wr_data     = '{is_free: 1'b1, cap: cap_ff};

      case (state_ff)
         S_BOOT, S_INIT: begin
            wr_en       = 1'b1;
            wr_addr     = '0;
            wr_data     = '{is_free: 1'b1, cap: heap_size - HEADER_BYTES};
            heap_end_in = heap_size;
            res_in      = '{status: STATUS_DONE, address: '0};
            state_in    = (state_ff == S_BOOT) ? S_IDLE : S_DONE;
         end
         S_IDLE: begin
            if (cmd_valid) begin
               o_in       = '0;
               q_in       = req_q;
               h_in       = cmd_data.block_address - HEADER_BYTES[ADDR_W-1:0];
               free_op_in = (cmd_data.cmd == CMD_FREE);
               res_in     = '{status: STATUS_DONE, address: '0};
               case (cmd_data.cmd)
                  CMD_ALLOC: state_in = S_RD;
                  CMD_FREE: begin
                     if ({1'b0, cmd_data.block_address} < HEADER_BYTES) begin
                        res_in   = '{status: STATUS_NULL, address: '0};
                        state_in = S_DONE;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  CMD_INIT: state_in = S_INIT;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = o_ff;
            state_in = S_CHK;
         end
         S_CHK: begin
            cap_in = rd_data_ff.cap;
            if (free_op_ff && o_ff == h_ff) begin
               // mark free, then absorb what follows
               wr_en    = 1'b1;
               wr_data  = '{is_free: 1'b1, cap: rd_data_ff.cap};
               state_in = S_MRD;
            end else if (free_op_ff && o_ff > h_ff) begin
               res_in   = '{status: STATUS_NULL, address: '0};
               state_in = S_DONE;
            end else if (!free_op_ff && rd_data_ff.is_free) begin
               state_in = (rd_data_ff.cap >= q_ff) ? S_FIT : S_MRD;
            end else if (next_rd >= {1'b0, heap_end_ff}) begin
               res_in   = free_op_ff ? '{status: STATUS_NULL, address: '0}
                                     : '{status: STATUS_OOM, address: '0};
               state_in = S_DONE;
            end else begin
               o_in     = next_rd[ADDR_W-1:0];
               state_in = S_RD;
            end
         end
         S_MRD: begin
            if (next_cur >= {1'b0, heap_end_ff}) begin
               // chain ends: free is finished, alloc has nothing left to try
               res_in   = free_op_ff ? '{status: STATUS_DONE, address: '0}
                                     : '{status: STATUS_OOM, address: '0};
               state_in = S_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = next_cur[ADDR_W-1:0];
               n_in     = next_cur[ADDR_W-1:0];
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            if (rd_data_ff.is_free) begin
               wr_en   = 1'b1;
               wr_data = '{is_free: 1'b1, cap: merged[SIZE_W-1:0]};
               cap_in  = merged[SIZE_W-1:0];
               if (!free_op_ff && merged[SIZE_W-1:0] >= q_ff) begin
                  state_in = S_FIT;
               end else begin
                  state_in = S_MRD;
               end
            end else if (free_op_ff) begin
               res_in   = '{status: STATUS_DONE, address: '0};
               state_in = S_DONE;
            end else begin
               // neighbor is in use: continue the walk there
               o_in     = n_ff;
               state_in = S_RD;
            end
         end
         S_FIT: begin
            if (split_need <= {1'b0, cap_ff}) begin
               wr_en   = 1'b1;
               wr_addr = tail_off[ADDR_W-1:0];
               wr_data = '{is_free: 1'b1, cap: tail_cap};
               cap_in  = q_ff;
            end
            state_in = S_USE;
         end
         S_USE: begin
            wr_en    = 1'b1;
            wr_data  = '{is_free: 1'b0, cap: cap_ff};
            res_in   = '{status: STATUS_DONE, address: o_ff + HEADER_BYTES[ADDR_W-1:0]};
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_BOOT;
      end else begin
         state_ff <= state_in;
      end
      free_op_ff  <= free_op_in;
      q_ff        <= q_in;
      h_ff        <= h_in;
      o_ff        <= o_in;
      n_ff        <= n_in;
      cap_ff      <= cap_in;
      heap_end_ff <= heap_end_in;
      res_ff      <= res_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hdr_mem_ff[rd_addr];
      end
   end

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res_data  = res_ff;

endmodule

// File: design/first_fit_heap_allocator.sv
// Alloc and free walk the block headers in address order and merge free neighbours;
//   init rebuilds the heap as one free block; a null free or unused command goes straight to the result.
// One command at a time; the header memory walk sets the rate.
// A new command is accepted while the previous result waits in the output register.
// Reset (synchronous): heap_bytes returns to 4096 and the S_BOOT state rebuilds the heap as one
//   free block before the first command is taken.
module first_fit_heap_allocator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [12:0]            csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ffha_pkg::ffha_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ffha_pkg::ffha_rsp_type rsp_data
);
   import ffha_pkg::*;

   logic [SIZE_W-1:0] heap_bytes_ff, heap_bytes_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ffha_rsp_type      rsp_data_ff, rsp_data_in;
   logic              res_valid;
   logic              res_ready;
   ffha_rsp_type      res_data;

   ffha_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .heap_bytes (heap_bytes_ff),
      .cmd_valid  (req_valid),
      .cmd_ready  (req_ready),
      .cmd_data   (req_data),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res_data   (res_data)
   );

   assign csr_ready = 1'b1;
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      heap_bytes_in = csr_valid ? csr_data : heap_bytes_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (res_ready) begin
         // load a new beat or drain the old one
         rsp_valid_in = res_valid;
         rsp_data_in  = res_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_bytes_ff <= HEAP_BYTES;
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_bytes_ff <= heap_bytes_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine took a command but stayed ready");

   a_fail_no_address: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_DONE |-> rsp_data.address == '0)
      else $error("failed command carries an address");

   a_addr_past_header: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.address != '0 |->
         {1'b0, rsp_data.address} >= HEADER_BYTES)
      else $error("allocated address overlaps the first header");

   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res_ready |=> res_valid && $stable(res_data))
      else $error("engine result lost while output register full");

endmodule
